@@ hdl/outer_spiral_scan_macros.svh @@
// ----------------------------------------------------------------------------
// outer_spiral_scan_macros.svh
// Assertion macros for the spiral scan block. Empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef OUTER_SPIRAL_SCAN_MACROS_SVH
`define OUTER_SPIRAL_SCAN_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted
`define OSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define OSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define OSS_ASSERT(label, prop, msg)
`define OSS_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ hdl/oss_pkg.sv @@
// ----------------------------------------------------------------------------
// oss_pkg
// Shared types for the spiral scan block: walker states and step status.
// ----------------------------------------------------------------------------
package oss_pkg;

  // Spiral walker: idle, then one state per edge of the current ring
  typedef enum logic [2:0] {
    OSS_IDLE,
    OSS_TOP,
    OSS_RIGHT,
    OSS_BOTTOM,
    OSS_LEFT
  } oss_state_t;

  // Status of the current walker step
  typedef struct packed {
    logic valid;  // a coordinate is presented this cycle
    logic last;   // it is the final coordinate of the scan
  } oss_step_t;

endpackage

@@ hdl/oss_spiral_gen.sv @@
// ----------------------------------------------------------------------------
// oss_spiral_gen
// Walks the coordinates of an N x N matrix in clockwise spiral order, one
// coordinate per cycle, ring by ring from the outside in.
// ----------------------------------------------------------------------------
module oss_spiral_gen
  import oss_pkg::*;
#(
  parameter int MAX_SIDE = 8,
  parameter int CW       = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          launch,
  input  logic [3:0]    side,
  output logic [CW-1:0] row,
  output logic [CW-1:0] col,
  output oss_step_t     step
);

  oss_state_t    state_r, state_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [3:0]    side_m1;
  logic          ring_wide;   // hi > lo
  logic          ring_deep;   // hi > lo + 1

  assign side_m1   = side - 4'd1;
  assign ring_wide = hi_r > lo_r;
  assign ring_deep = {1'b0, hi_r} > ({1'b0, lo_r} + {{CW{1'b0}}, 1'b1});

  // Next state and coordinate update
  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    unique case (state_r)
      OSS_IDLE: begin
        if (launch) begin
          state_nxt = OSS_TOP;
          lo_nxt    = '0;
          hi_nxt    = side_m1[CW-1:0];
          row_nxt   = '0;
          col_nxt   = '0;
        end
      end
      OSS_TOP: begin
        if (col_r == hi_r) begin
          if (ring_wide) begin
            state_nxt = OSS_RIGHT;
            row_nxt   = row_r + 1'b1;
          end else begin
            state_nxt = OSS_IDLE;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      OSS_RIGHT: begin
        if (row_r == hi_r) begin
          state_nxt = OSS_BOTTOM;
          col_nxt   = col_r - 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      OSS_BOTTOM: begin
        if (col_r == lo_r) begin
          if (ring_deep) begin
            state_nxt = OSS_LEFT;
            row_nxt   = row_r - 1'b1;
          end else begin
            state_nxt = OSS_IDLE;
          end
        end else begin
          col_nxt = col_r - 1'b1;
        end
      end
      OSS_LEFT: begin
        if (row_r == lo_r + 1'b1) begin
          // move to the next inner ring
          state_nxt = OSS_TOP;
          lo_nxt    = lo_r + 1'b1;
          hi_nxt    = hi_r - 1'b1;
          row_nxt   = lo_r + 1'b1;
          col_nxt   = lo_r + 1'b1;
        end else begin
          row_nxt = row_r - 1'b1;
        end
      end
      default: state_nxt = OSS_IDLE;
    endcase
  end

  // Step status: the final coordinate is the one that returns to idle
  always_comb begin
    step.valid = 1'b1;
    step.last  = 1'b0;
    unique case (state_r)
      OSS_IDLE:   step.valid = 1'b0;
      OSS_TOP:    step.last  = (col_r == hi_r) && !ring_wide;
      OSS_RIGHT:  step.last  = 1'b0;
      OSS_BOTTOM: step.last  = (col_r == lo_r) && !ring_deep;
      OSS_LEFT:   step.last  = 1'b0;
      default:    step.valid = 1'b0;
    endcase
  end

  assign row = row_r;
  assign col = col_r;

  // Walker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OSS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    row_r <= row_nxt;
    col_r <= col_nxt;
  end

endmodule

@@ hdl/outer_spiral_scan.sv @@
// ----------------------------------------------------------------------------
// outer_spiral_scan
// Loads an N x N matrix in row-major order and plays it back in clockwise
// spiral order.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while busy is low and written straight
// into the matrix memory. The transfer that completes the matrix starts the
// scan: busy rises on the next cycle and stays high until the last
// coordinate has been read, one memory read per coordinate. Each result
// appears on out_value for exactly one cycle with out_valid, in the cycle
// after its read, so results arrive back to back, the final one with
// out_last_out. The receiver cannot stall the scan; it must take every
// strobe. Loading is held off while busy, so the next matrix cannot be
// loaded during a scan; the final result appears in the cycle after the
// last scan step and overlaps the next load. The first element of the next
// matrix can be taken in that same cycle.
// cfg_side_length sets N (0 acts as 1, values above MAX_SIDE act as
// MAX_SIDE) and restarts loading at the top left corner; write it only while
// the block is idle.
// ----------------------------------------------------------------------------
`include "outer_spiral_scan_macros.svh"

module outer_spiral_scan
  import oss_pkg::*;
#(
  parameter int MAX_SIDE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // element load channel
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_element,
  // spiral result channel
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic               out_last_out,
  // side length register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_side_length
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int CW    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int PW    = CW + 4;

  logic [3:0]         side_r, side_nxt;
  logic [3:0]         side_eff;
  logic [7:0]         total;
  logic [LW-1:0]      load_count_r, load_count_nxt;
  logic [LW-1:0]      cnt_inc;
  logic               in_xfer;
  logic               cfg_xfer;
  logic               completing;
  logic [CW-1:0]      scan_row;
  logic [CW-1:0]      scan_col;
  oss_step_t          step;
  logic [PW-1:0]      rd_lin;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;
  logic               out_valid_r;
  logic               out_last_r;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign busy      = step.valid;
  assign in_xfer   = start && !busy;

  // Effective side: zero acts as one, saturate at the maximum
  always_comb begin
    if (side_r == 4'd0) begin
      side_eff = 4'd1;
    end else if (side_r > 4'(MAX_SIDE)) begin
      side_eff = 4'(MAX_SIDE);
    end else begin
      side_eff = side_r;
    end
  end

  assign total      = {4'd0, side_eff} * {4'd0, side_eff};
  assign cnt_inc    = load_count_r + 1'b1;
  assign completing = in_xfer && (8'(cnt_inc) == total);

  // Side register and load counter
  always_comb begin
    side_nxt       = side_r;
    load_count_nxt = load_count_r;
    if (cfg_xfer) begin
      side_nxt       = cfg_side_length;
      load_count_nxt = '0;
    end else if (in_xfer) begin
      load_count_nxt = completing ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r       <= 4'd4;
      load_count_r <= '0;
    end else begin
      side_r       <= side_nxt;
      load_count_r <= load_count_nxt;
    end
  end

  // Spiral coordinate walker
  oss_spiral_gen #(
    .MAX_SIDE (MAX_SIDE),
    .CW       (CW)
  ) u_gen (
    .clk    (clk),
    .rst_n  (rst_n),
    .launch (completing),
    .side   (side_eff),
    .row    (scan_row),
    .col    (scan_col),
    .step   (step)
  );

  // Read address: row * N + col
  assign rd_lin  = PW'(scan_row) * PW'(side_eff) + PW'(scan_col);
  assign rd_addr = rd_lin[AW-1:0];

  // Matrix memory: one write port for loading, one registered read port
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mem[load_count_r[AW-1:0]] <= in_element;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Result strobe follows the read in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= step.valid;
      out_last_r  <= step.valid && step.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = rd_data_r;
  assign out_last_out = out_last_r;

  // Checks
  `OSS_ASSERT(a_strobe_from_scan, out_valid |-> $past(busy), "result without a scan step")
  `OSS_ASSERT(a_last_ends_burst, (out_valid && out_last_out) |=> !out_valid, "strobe after last")
  `OSS_ASSERT(a_complete_starts, completing |=> busy, "completed matrix did not start a scan")
  `OSS_ASSERT(a_count_in_range, !busy |-> (8'(load_count_r) < total), "load count past matrix")

endmodule
